### rtl/sghoa_pkg.sv
// ----------------------------------------------------------------------------
// sghoa_pkg
// Shared types and constants for the sample group hold-or-average block.
// ----------------------------------------------------------------------------
package sghoa_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int GSIZE_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE = 1'b1;

	localparam logic MODE_AVERAGE = 1'b0;
	localparam logic MODE_HOLD    = 1'b1;

	// What the current run emits
	typedef enum logic [1:0] {
		SEL_PASS,
		SEL_HOLD,
		SEL_AVG
	} sel_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic acc;
		logic clr;
		logic start_emit;
		logic next;
		logic div_start;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit;
		logic last;
		logic avg;
		logic div_busy;
	} dp_stat_t;

endpackage

### rtl/sghoa_ram.sv
// ----------------------------------------------------------------------------
// sghoa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sghoa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sghoa_div.sv
// ----------------------------------------------------------------------------
// sghoa_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module sghoa_div #(
	parameter int DIVIDEND_W = 30,
	parameter int DIVISOR_W  = 7,
	parameter int QUOT_W     = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]         divisor,
	output logic                         busy,
	output logic [QUOT_W-1:0]            quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] mag_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  busy_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;
	logic [DIVIDEND_W-1:0] q_full;

	// Trial subtraction for the next quotient bit
	assign trial = {rem_q, mag_q[DIVIDEND_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVIDEND_W-1];
			mag_q <= dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVISOR_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
			mag_q <= {mag_q[DIVIDEND_W-2:0], fits};
		end
	end

	// Restore the sign
	assign q_full   = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = q_full[QUOT_W-1:0];
	assign busy     = busy_q;

endmodule

### rtl/sghoa_datapath.sv
// ----------------------------------------------------------------------------
// sghoa_datapath
// Group store, running count and sum, configuration registers, divider and
// result selection.
// ----------------------------------------------------------------------------
module sghoa_datapath
	import sghoa_pkg::*;
#(
	parameter int MAX_GROUP   = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic                   block_end,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic                   last_of_run
);

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int AW    = $clog2(MAX_GROUP);
	localparam int SUM_W = SAMPLE_BITS + AW;
	localparam logic [GSIZE_W-1:0] MAX_SIZE = GSIZE_W'(MAX_GROUP);

	logic [GSIZE_W-1:0]     group_size_q;
	logic                   merge_mode_q;
	logic [CNT_W-1:0]       count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]       k_q;
	sel_t                   sel_q;

	logic [CNT_W-1:0]       eff_size;
	logic [CNT_W-1:0]       n_next;
	logic [CNT_W-1:0]       k_plus;
	logic                   full;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] quotient;
	logic                   div_busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GSIZE_W'(1);
			merge_mode_q <= MODE_AVERAGE;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_GROUP_SIZE: group_size_q <= cfg_wdata[GSIZE_W-1:0];
				REG_MERGE_MODE: merge_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp the group size to 1..MAX_GROUP
	always_comb begin
		if (group_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (group_size_q > MAX_SIZE) begin
			eff_size = CNT_W'(MAX_GROUP);
		end else begin
			eff_size = group_size_q[CNT_W-1:0];
		end
	end

	assign n_next = count_q + 1'b1;
	assign full   = (n_next >= eff_size);
	assign k_plus = k_q + 1'b1;

	// Gather samples, select the run type, walk the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			k_q     <= '0;
			sel_q   <= SEL_PASS;
		end else begin
			if (cmd.acc) begin
				count_q <= n_next;
				sum_q   <= sum_q + {{AW{sample_in[SAMPLE_BITS-1]}}, sample_in};
				if (!full) begin
					sel_q <= SEL_PASS;
				end else if (merge_mode_q == MODE_HOLD) begin
					sel_q <= SEL_HOLD;
				end else begin
					sel_q <= SEL_AVG;
				end
			end else if (cmd.clr) begin
				count_q <= '0;
				sum_q   <= '0;
			end
			if (cmd.start_emit) begin
				k_q <= '0;
			end else if (cmd.next) begin
				k_q <= k_plus;
			end
		end
	end

	// Read the first entry at the start of a run; in pass-through walk the store
	assign ram_re    = cmd.start_emit || (cmd.next && (sel_q == SEL_PASS));
	assign ram_raddr = cmd.start_emit ? '0 : k_plus[AW-1:0];

	sghoa_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_GROUP)
	) u_store (
		.clk   (clk),
		.we    (cmd.acc),
		.waddr (count_q[AW-1:0]),
		.wdata (sample_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sghoa_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W),
		.QUOT_W     (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Result selection and status
	assign sample_out  = (sel_q == SEL_AVG) ? quotient : ram_rdata;
	assign last_of_run = (k_plus == count_q);

	assign stat.emit     = full || block_end;
	assign stat.last     = (k_plus == count_q);
	assign stat.avg      = (sel_q == SEL_AVG);
	assign stat.div_busy = div_busy;

endmodule

### rtl/sghoa_ctrl.sv
// ----------------------------------------------------------------------------
// sghoa_ctrl
// Controller: accepts items, starts a run when a group closes, sequences
// the divider and hands results out one by one.
// ----------------------------------------------------------------------------
module sghoa_ctrl
	import sghoa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.acc = 1'b1;
					if (stat.emit) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.start_emit = 1'b1;
				cmd.div_start  = stat.avg;
				state_d        = stat.avg ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (stat.last) begin
						cmd.clr = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/sample_group_hold_or_average_top.sv
// ----------------------------------------------------------------------------
// sample_group_hold_or_average_top
// Boxcar average / sample-and-hold over groups of signed audio samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block gathers a group; when the
// group reaches group_size (or an item carries block_end) the block stops
// taking items, reads the group store, and then offers one result per
// gathered sample, one per cycle while m_tready is high, with tlast on the
// final one. In average mode the iterative divider runs between the store
// read and the first result, one quotient bit per cycle. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sample_group_hold_or_average_top
	import sghoa_pkg::*;
#(
	parameter int MAX_GROUP   = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [CFG_IDX_W-1:0]              cfg_addr,
	input  logic [CFG_DATA_W-1:0]             cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: sample_in [SAMPLE_BITS-1:0], zero padding above
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
	// s_tuser: block_end [0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: sample_out [SAMPLE_BITS-1:0], zero padding above
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
	output logic                              m_tlast
);

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	dp_cmd_t                cmd;
	dp_stat_t               stat;
	logic [SAMPLE_BITS-1:0] sample_out;

	sghoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sghoa_datapath #(
		.MAX_GROUP   (MAX_GROUP),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.sample_in   (s_tdata[SAMPLE_BITS-1:0]),
		.block_end   (s_tuser),
		.cmd         (cmd),
		.stat        (stat),
		.sample_out  (sample_out),
		.last_of_run (m_tlast)
	);

	// Pad the result to whole bytes
	assign m_tdata = TDATA_W'(sample_out);

endmodule

### verif/sample_group_checker.sv
// ----------------------------------------------------------------------------
// sample_group_checker
// Watches the stream and configuration ports of the group hold-or-average
// block. It keeps its own copy of the registers and of the group being
// gathered, works out the samples each accepted item releases, and compares
// every returned item with the oldest outstanding sample, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sample_group_checker
	import sghoa_pkg::*;
#(
	parameter int MAX_GROUP   = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [CFG_IDX_W-1:0]              cfg_addr,
	input  logic [CFG_DATA_W-1:0]             cfg_wdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// s_tdata: sample_in [SAMPLE_BITS-1:0], zero padding above
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
	// s_tuser: block_end [0]
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: sample_out [SAMPLE_BITS-1:0], zero padding above
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
	input  logic                              m_tlast,
	output int unsigned                       fail_count,
	output int unsigned                       pending
);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last;
	} merged_t;

	// Samples still owed by the block, oldest first
	merged_t merged_q[$];

	// Own copy of the registers and of the group being gathered
	logic [GSIZE_W-1:0]            size_reg;
	logic                          mode_reg;
	logic signed [SAMPLE_BITS-1:0] held[MAX_GROUP];
	int unsigned                   gathered;
	longint                        group_total;
	int unsigned                   errors;
	merged_t                       want;

	// Add one sample to the group; release the group when full or at block end
	task automatic merge_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic blk_end);
		int unsigned                   limit;
		longint                        mean;
		logic signed [SAMPLE_BITS-1:0] value;
		limit = (size_reg == '0) ? 1 : (size_reg > MAX_GROUP) ? MAX_GROUP : size_reg;
		held[gathered] = smp;
		gathered++;
		group_total += smp;
		if (gathered >= limit || blk_end) begin
			// signed division truncates toward zero
			mean = group_total / longint'(gathered);
			for (int k = 0; k < gathered; k++) begin
				if (gathered < limit)
					value = held[k];
				else if (mode_reg == MODE_HOLD)
					value = held[0];
				else
					value = mean[SAMPLE_BITS-1:0];
				merged_q.push_back('{value, k == gathered - 1});
			end
			gathered = 0;
			group_total = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merged_q.delete();
			size_reg = 1;
			mode_reg = MODE_AVERAGE;
			gathered = 0;
			group_total = 0;
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// predict from each accepted item
			if (s_tvalid && s_tready)
				merge_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser);

			// compare each returned item with the oldest owed sample
			if (m_tvalid && m_tready) begin
				if (merged_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, got sample %h last %b",
						$time, m_tdata[SAMPLE_BITS-1:0], m_tlast);
				end else begin
					want = merged_q.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
						errors++;
						$display("%0t: sample_out mismatch, expected %h, got %h",
							$time, want.sample, m_tdata[SAMPLE_BITS-1:0]);
					end
					if (m_tlast !== want.last) begin
						errors++;
						$display("%0t: last_of_run mismatch, expected %b, got %b",
							$time, want.last, m_tlast);
					end
				end
			end

			// track register writes
			if (cfg_wen) begin
				case (cfg_addr)
					REG_GROUP_SIZE: size_reg = cfg_wdata[GSIZE_W-1:0];
					REG_MERGE_MODE: mode_reg = cfg_wdata[0];
					default: ;
				endcase
			end

			fail_count <= errors;
			pending <= merged_q.size();
		end
	end

endmodule

### verif/sample_group_hold_or_average_top_tb.sv
// ----------------------------------------------------------------------------
// sample_group_hold_or_average_top_tb
// Drives the group hold-or-average block with a directed opening (extreme
// samples, both modes, zero and largest group sizes, partial groups at
// block end, a group size lowered mid-group) and then random phases at
// several settings, with random stalls on both streams. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sample_group_hold_or_average_top_tb;
	import sghoa_pkg::*;

	localparam int MAX_GROUP     = 64;
	localparam int SAMPLE_BITS   = 24;
	localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
	// store read plus the iterative divider, with margin
	localparam int SETTLE_CYCLES = 48;

	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;
	logic                  m_tlast;
	int unsigned           fail_count;
	int unsigned           pending;
	logic                  calm;
	int unsigned           stall_left;

	sample_group_hold_or_average_top #(
		.MAX_GROUP   (MAX_GROUP),
		.SAMPLE_BITS (SAMPLE_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	sample_group_checker #(
		.MAX_GROUP   (MAX_GROUP),
		.SAMPLE_BITS (SAMPLE_BITS)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Stall the result stream in random bursts, never once calm
	initial begin
		m_tready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 5);
			m_tready <= (stall_left == 0);
		end
	end

	// Offer one item, after an optional random gap, and hold until accepted;
	// s_tready only moves after a rising edge, so look at it mid-cycle
	task automatic send_item(input logic [SAMPLE_BITS-1:0] smp, input logic blk_end);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(smp);
		s_tuser <= blk_end;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	// Stop sending, wait for every owed item, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back
	task automatic configure(input logic [CFG_DATA_W-1:0] size, input logic mode);
		cfg_wen <= 1'b1;
		cfg_addr <= REG_GROUP_SIZE;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_addr <= REG_MERGE_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Favour the extremes now and then
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// One random phase at a fixed setting; block_end once in end_odds items
	task automatic run_phase(input logic [CFG_DATA_W-1:0] size, input logic mode,
		input int unsigned count, input int unsigned end_odds, input bit min_heavy);
		logic [SAMPLE_BITS-1:0] smp;
		logic                   blk_end;
		drain();
		configure(size, mode);
		for (int i = 0; i < count; i++) begin
			smp = (min_heavy && $urandom_range(0, 3) != 0) ? S_MIN : pick_sample();
			blk_end = (end_odds != 0) && ($urandom_range(1, end_odds) == 1);
			send_item(smp, blk_end);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_addr <= REG_GROUP_SIZE;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		calm <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: groups of one, each item comes back as it is
		send_item(S_MAX, 1'b0);
		send_item(S_MIN, 1'b1);

		// zero group size behaves as one
		drain();
		configure(7'd0, MODE_AVERAGE);
		send_item(SAMPLE_BITS'(24'h555555), 1'b0);

		// average truncates toward zero, and a full-scale group stays full scale
		drain();
		configure(7'd3, MODE_AVERAGE);
		send_item('1, 1'b0);
		send_item('1, 1'b0);
		send_item(SAMPLE_BITS'(1), 1'b0);
		send_item(S_MAX, 1'b0);
		send_item(S_MAX, 1'b0);
		send_item(S_MAX, 1'b0);

		// hold the first sample, then pass a partial group through at block end
		drain();
		configure(7'd3, MODE_HOLD);
		send_item(SAMPLE_BITS'(7), 1'b0);
		send_item(SAMPLE_BITS'(1), 1'b0);
		send_item(SAMPLE_BITS'(2), 1'b0);
		send_item(SAMPLE_BITS'(9), 1'b0);
		send_item(SAMPLE_BITS'(-4), 1'b1);

		// lower the group size with a partial group gathered
		drain();
		configure(7'd5, MODE_AVERAGE);
		send_item(SAMPLE_BITS'(10), 1'b0);
		send_item(SAMPLE_BITS'(20), 1'b0);
		send_item(SAMPLE_BITS'(-30), 1'b0);
		drain();
		configure(7'd2, MODE_AVERAGE);
		send_item(SAMPLE_BITS'(41), 1'b0);

		// largest size, closed early by block end
		drain();
		configure(7'd64, MODE_HOLD);
		send_item(S_MIN, 1'b0);
		send_item(S_MAX, 1'b1);

		// random phases
		run_phase(7'($urandom_range(2, 6)), MODE_AVERAGE, 20, 10, 1'b0);
		run_phase(7'($urandom_range(2, 6)), MODE_HOLD, 20, 10, 1'b0);
		// size above the store saturates; mostly full-scale negative samples
		run_phase(7'd127, MODE_AVERAGE, 64, 0, 1'b1);

		// last part runs without idling on either side
		calm <= 1'b1;
		run_phase(7'($urandom_range(1, 4)), MODE_HOLD, 12, 6, 1'b0);
		send_item(pick_sample(), 1'b1);

		drain();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
